FILE: hw/rtl/i2cmb_pkg.sv
// ---------------------------------------------------------------------------
// i2cmb_pkg
// Shared types, codes and helpers of the I2C master bit engine.
// ---------------------------------------------------------------------------
package i2cmb_pkg;

    // Width of the hold counter
    localparam int HOLD_BITS = 16;
    // Width of the configured hold value
    localparam int CFG_BITS  = 16;
    // Step index width (longest sequence is 25 steps)
    localparam int STEP_BITS = 5;

    localparam logic [CFG_BITS-1:0] HOLD_RESET = CFG_BITS'(10);
    localparam logic [31:0] HOLD_MAX = 32'((64'(1) << HOLD_BITS) - 64'(1));

    // Command codes
    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_STOP      = 3'd1,
        MODE_SEND_BYTE = 3'd2,
        MODE_RECV_BYTE = 3'd3,
        MODE_SEND_ACK  = 3'd4,
        MODE_RECV_ACK  = 3'd5
    } mode_t;

    // One tick as seen by the core
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic       sda_in;
    } item_t;

    // One result as produced by the core
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } result_t;

    // Number of steps in each sequence
    function automatic logic [STEP_BITS-1:0] seq_len(input mode_t m);
        logic [STEP_BITS-1:0] len;
        unique case (m)
            MODE_START:     len = STEP_BITS'(4);
            MODE_STOP:      len = STEP_BITS'(3);
            MODE_SEND_BYTE: len = STEP_BITS'(24);
            MODE_RECV_BYTE: len = STEP_BITS'(25);
            MODE_SEND_ACK:  len = STEP_BITS'(3);
            MODE_RECV_ACK:  len = STEP_BITS'(4);
            default:        len = STEP_BITS'(0);
        endcase
        return len;
    endfunction

    // Hold reload: zero acts as one, saturate at counter range
    function automatic logic [HOLD_BITS-1:0] hold_load(input logic [CFG_BITS-1:0] h);
        logic [31:0] v;
        v = 32'(h);
        if (v == 32'd0) begin
            v = 32'd1;
        end
        if (v > HOLD_MAX) begin
            v = HOLD_MAX;
        end
        return v[HOLD_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/i2cmb_if.sv
// ---------------------------------------------------------------------------
// i2cmb_if
// Valid/ready channels of the I2C master bit engine: tick in, result out.
// ---------------------------------------------------------------------------
interface i2cmb_in_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;

    modport source (output valid, cmd_valid, mode, tx_byte, ack_out, sda_in, input ready);
    modport sink   (input valid, cmd_valid, mode, tx_byte, ack_out, sda_in, output ready);
endinterface

interface i2cmb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_in;

    modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                    ack_in, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                    ack_in, output ready);
endinterface

FILE: hw/rtl/i2cmb_core.sv
// ---------------------------------------------------------------------------
// i2cmb_core
// Sequencer state of the bit engine; advances one tick per accepted transfer
// and presents the result of that tick combinationally.
// ---------------------------------------------------------------------------
module i2cmb_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  i2cmb_pkg::item_t                item,
    input  logic [i2cmb_pkg::CFG_BITS-1:0]  hold_ticks,
    output i2cmb_pkg::result_t              result
);
    import i2cmb_pkg::*;

    logic [STEP_BITS-1:0] step_reg,  step_next;
    logic [HOLD_BITS-1:0] hold_reg,  hold_next;
    mode_t                mode_reg,  mode_next;
    logic                 busy_reg,  busy_next;
    logic [7:0]           tx_reg,    tx_next;
    logic [7:0]           rx_reg,    rx_next;
    logic                 ack_reg,   ack_next;
    logic                 scl_reg,   scl_next;
    logic                 sda_reg,   sda_next;
    // bit position and phase within a three-step bit slot
    logic [1:0]           phase_reg, phase_next;
    logic [2:0]           bit_reg,   bit_next;

    logic                 fire;
    logic                 done;
    logic [HOLD_BITS-1:0] hold_dec;
    logic [STEP_BITS-1:0] step_inc;

    // Next-state and step action
    always_comb
    begin
        step_next  = step_reg;
        hold_next  = hold_reg;
        mode_next  = mode_reg;
        busy_next  = busy_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        fire       = 1'b0;
        done       = 1'b0;
        hold_dec   = (hold_reg != '0) ? hold_reg - HOLD_BITS'(1) : hold_reg;
        step_inc   = step_reg + STEP_BITS'(1);

        if (!busy_reg) begin
            // idle: take a valid command, ignore unknown codes
            if (item.cmd_valid && (item.mode <= 3'(MODE_RECV_ACK))) begin
                mode_next = mode_t'(item.mode);
                busy_next = 1'b1;
                step_next = '0;
                fire      = 1'b1;
                if (mode_t'(item.mode) == MODE_SEND_BYTE) begin
                    tx_next = item.tx_byte;
                end
                if (mode_t'(item.mode) == MODE_RECV_BYTE) begin
                    rx_next    = '0;
                    // receive byte has a set-up step before bit 0
                    phase_next = 2'd2;
                    bit_next   = 3'd7;
                end else begin
                    phase_next = 2'd0;
                    bit_next   = 3'd0;
                end
            end
        end else begin
            hold_next = hold_dec;
            if (hold_dec == '0) begin
                if (step_inc < seq_len(mode_reg)) begin
                    step_next = step_inc;
                    fire      = 1'b1;
                    if (phase_reg == 2'd2) begin
                        phase_next = 2'd0;
                        bit_next   = bit_reg + 3'd1;
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end else begin
                    busy_next = 1'b0;
                    step_next = '0;
                    done      = 1'b1;
                end
            end
        end

        // carry out the step and reload the hold
        if (fire) begin
            hold_next = hold_load(hold_ticks);
            unique case (mode_next)
                MODE_START:
                begin
                    if (step_next == STEP_BITS'(0))      sda_next = 1'b1;
                    else if (step_next == STEP_BITS'(1)) scl_next = 1'b1;
                    else if (step_next == STEP_BITS'(2)) sda_next = 1'b0;
                    else                                 scl_next = 1'b0;
                end
                MODE_STOP:
                begin
                    if (step_next == STEP_BITS'(0))      sda_next = 1'b0;
                    else if (step_next == STEP_BITS'(1)) scl_next = 1'b1;
                    else                                 sda_next = 1'b1;
                end
                MODE_SEND_BYTE:
                begin
                    if (phase_next == 2'd0)      sda_next = tx_next[3'd7 - bit_next];
                    else if (phase_next == 2'd1) scl_next = 1'b1;
                    else                         scl_next = 1'b0;
                end
                MODE_RECV_BYTE:
                begin
                    if (step_next == STEP_BITS'(0)) begin
                        sda_next = 1'b1;
                    end else if (phase_next == 2'd0) begin
                        scl_next = 1'b1;
                    end else if (phase_next == 2'd1) begin
                        if (item.sda_in) begin
                            rx_next[3'd7 - bit_next] = 1'b1;
                        end
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                MODE_SEND_ACK:
                begin
                    if (step_next == STEP_BITS'(0))      sda_next = item.ack_out;
                    else if (step_next == STEP_BITS'(1)) scl_next = 1'b1;
                    else                                 scl_next = 1'b0;
                end
                MODE_RECV_ACK:
                begin
                    if (step_next == STEP_BITS'(0))      sda_next = 1'b1;
                    else if (step_next == STEP_BITS'(1)) scl_next = 1'b1;
                    else if (step_next == STEP_BITS'(2)) ack_next = item.sda_in;
                    else                                 scl_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of this tick, taken from the post-step state
    always_comb
    begin
        result.scl_level = scl_next;
        result.sda_level = sda_next;
        result.busy_res  = busy_next;
        result.done_res  = done;
        result.rx_byte   = rx_next;
        result.ack_in    = ack_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg  <= '0;
            hold_reg  <= '0;
            mode_reg  <= MODE_START;
            busy_reg  <= 1'b0;
            tx_reg    <= '0;
            rx_reg    <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            phase_reg <= '0;
            bit_reg   <= '0;
        end else if (step_en) begin
            step_reg  <= step_next;
            hold_reg  <= hold_next;
            mode_reg  <= mode_next;
            busy_reg  <= busy_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

FILE: hw/rtl/i2c_master_bit_engine_unit.sv
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// Bit-level I2C master: one timebase tick in, one pin/status result out.
// ---------------------------------------------------------------------------
//  channel   dir  transfer carries
//  cmd       in   cmd_valid, mode, tx_byte, ack_out, sda_in (one tick)
//  res       out  scl_level, sda_level, busy_res, done_res, rx_byte, ack_in
//  hold_*    in   hold_ticks write, no read-back
//
//  One tick is taken every clock cycle unless res stalls; its result sits
//  in out_reg next cycle, set by the single sequencer update in the core.
//  A new tick is taken while the output register is empty or being drained.
//  When res stalls, cmd stalls with it and the sequencer state holds.
//  Reset releases both lines (SCL and SDA high), idle, hold_ticks = 10.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    i2cmb_in_if.sink                        cmd,
    i2cmb_out_if.source                     res,
    input  logic                            hold_we,
    input  logic [i2cmb_pkg::CFG_BITS-1:0]  hold_wdata
);
    import i2cmb_pkg::*;

    logic [CFG_BITS-1:0] hold_ticks_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    item_t               item;
    result_t             result;
    logic                accept;

    // Handshake: output register parts the two sides
    assign cmd.ready = !out_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        item.cmd_valid = cmd.cmd_valid;
        item.mode      = cmd.mode;
        item.tx_byte   = cmd.tx_byte;
        item.ack_out   = cmd.ack_out;
        item.sda_in    = cmd.sda_in;
    end

    i2cmb_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .item       (item),
        .hold_ticks (hold_ticks_reg),
        .result     (result)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_ticks_reg <= HOLD_RESET;
        end else if (hold_we) begin
            hold_ticks_reg <= hold_wdata;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (res.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.scl_level = out_reg.scl_level;
    assign res.sda_level = out_reg.sda_level;
    assign res.busy_res  = out_reg.busy_res;
    assign res.done_res  = out_reg.done_res;
    assign res.rx_byte   = out_reg.rx_byte;
    assign res.ack_in    = out_reg.ack_in;

endmodule

FILE: bench/i2c_master_bit_engine_unit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_unit_checker
// Watches the tick and result channels and the hold write port of the bit
// engine. It keeps its own copy of the sequencer to work out the pin levels
// and status that each accepted tick should give. It then checks every
// result transfer, field by field, against the oldest outstanding one.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_unit_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    i2cmb_in_if                             cmd,
    i2cmb_out_if                            res,
    input  logic                            hold_we,
    input  logic [i2cmb_pkg::CFG_BITS-1:0]  hold_wdata,
    output int                              fail_count,
    output int                              pending
);
    import i2cmb_pkg::*;

    // Shadow of the engine state
    logic [CFG_BITS-1:0]  hold_cfg;
    logic [STEP_BITS-1:0] step_idx;
    logic [HOLD_BITS-1:0] hold_left;
    mode_t                seq_mode;
    logic                 seq_busy;
    logic [7:0]           tx_shift;
    logic [7:0]           rx_shift;
    logic                 ack_sampled;
    logic                 scl_drv;
    logic                 sda_drv;

    // Pin levels and status still owed by the engine, oldest first
    result_t              pin_levels_q[$];

    // Counter reload: zero behaves as one. The configured value is no wider
    // than the counter, so it never needs clipping.
    function automatic logic [HOLD_BITS-1:0] hold_reload();
        if (hold_cfg == '0)
            return HOLD_BITS'(1);
        return HOLD_BITS'(hold_cfg);
    endfunction

    function automatic int steps_in(mode_t m);
        case (m)
            MODE_START:     return 4;
            MODE_STOP:      return 3;
            MODE_SEND_BYTE: return 24;
            MODE_RECV_BYTE: return 25;
            MODE_SEND_ACK:  return 3;
            MODE_RECV_ACK:  return 4;
            default:        return 0;
        endcase
    endfunction

    // Carry out one step of the running sequence
    function automatic void play_step(int idx, logic sda_now, logic ack_now);
        int bit_no;
        int phase;
        case (seq_mode)
            MODE_START:
            begin
                case (idx)
                    0:       sda_drv = 1'b1;
                    1:       scl_drv = 1'b1;
                    2:       sda_drv = 1'b0;
                    default: scl_drv = 1'b0;
                endcase
            end
            MODE_STOP:
            begin
                case (idx)
                    0:       sda_drv = 1'b0;
                    1:       scl_drv = 1'b1;
                    default: sda_drv = 1'b1;
                endcase
            end
            MODE_SEND_BYTE:
            begin
                bit_no = (idx / 3) % 8;
                phase  = idx % 3;
                case (phase)
                    0:       sda_drv = tx_shift[7 - bit_no];
                    1:       scl_drv = 1'b1;
                    default: scl_drv = 1'b0;
                endcase
            end
            MODE_RECV_BYTE:
            begin
                if (idx == 0)
                begin
                    sda_drv = 1'b1;
                end
                else
                begin
                    bit_no = ((idx - 1) / 3) % 8;
                    phase  = (idx - 1) % 3;
                    case (phase)
                        0:       scl_drv = 1'b1;
                        1:       if (sda_now) rx_shift[7 - bit_no] = 1'b1;
                        default: scl_drv = 1'b0;
                    endcase
                end
            end
            MODE_SEND_ACK:
            begin
                case (idx)
                    0:       sda_drv = ack_now;
                    1:       scl_drv = 1'b1;
                    default: scl_drv = 1'b0;
                endcase
            end
            default:
            begin
                case (idx)
                    0:       sda_drv = 1'b1;
                    1:       scl_drv = 1'b1;
                    2:       ack_sampled = sda_now;
                    default: scl_drv = 1'b0;
                endcase
            end
        endcase
    endfunction

    // Advance the shadow sequencer by one tick and return the pin levels
    function automatic result_t advance_tick(logic cv, logic [2:0] m, logic [7:0] txb,
                                             logic ack, logic sda);
        result_t r;
        logic    done;
        int      nxt;
        done = 1'b0;
        if (!seq_busy)
        begin
            // codes above receive ack are not commands
            if (cv && m <= MODE_RECV_ACK)
            begin
                seq_mode = mode_t'(m);
                seq_busy = 1'b1;
                step_idx = '0;
                if (seq_mode == MODE_SEND_BYTE) tx_shift = txb;
                if (seq_mode == MODE_RECV_BYTE) rx_shift = '0;
                play_step(0, sda, ack);
                hold_left = hold_reload();
            end
        end
        else
        begin
            if (hold_left != '0) hold_left = hold_left - 1'b1;
            if (hold_left == '0)
            begin
                nxt = int'(step_idx) + 1;
                if (nxt < steps_in(seq_mode))
                begin
                    step_idx = STEP_BITS'(nxt);
                    play_step(nxt, sda, ack);
                    hold_left = hold_reload();
                end
                else
                begin
                    seq_busy = 1'b0;
                    step_idx = '0;
                    done     = 1'b1;
                end
            end
        end
        r.scl_level = scl_drv;
        r.sda_level = sda_drv;
        r.busy_res  = seq_busy;
        r.done_res  = done;
        r.rx_byte   = rx_shift;
        r.ack_in    = ack_sampled;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare result transfers, then predict for tick transfers
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            hold_cfg    = HOLD_RESET;
            step_idx    = '0;
            hold_left   = '0;
            seq_mode    = MODE_START;
            seq_busy    = 1'b0;
            tx_shift    = '0;
            rx_shift    = '0;
            ack_sampled = 1'b0;
            scl_drv     = 1'b1;
            sda_drv     = 1'b1;
            pin_levels_q.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (hold_we)
                hold_cfg = hold_wdata;

            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                if (pin_levels_q.size() == 0)
                begin
                    $error("result transfer with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pin_levels_q.pop_front();
                    check_field("scl_level", 8'(want.scl_level), 8'(res.scl_level));
                    check_field("sda_level", 8'(want.sda_level), 8'(res.sda_level));
                    check_field("busy_res",  8'(want.busy_res),  8'(res.busy_res));
                    check_field("done_res",  8'(want.done_res),  8'(res.done_res));
                    check_field("rx_byte",   want.rx_byte,       res.rx_byte);
                    check_field("ack_in",    8'(want.ack_in),    8'(res.ack_in));
                end
            end

            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                pin_levels_q.push_back(advance_tick(cmd.cmd_valid, cmd.mode, cmd.tx_byte,
                                                    cmd.ack_out, cmd.sda_in));

            pending = pin_levels_q.size();
        end
    end

endmodule

FILE: bench/i2c_master_bit_engine_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_unit_test
// Top of the bit engine bench: drives ticks and hold writes and throttles
// the result channel. A directed pass covers every command, byte and ack
// extremes, ignored codes and commands landing while busy. Random commands
// then run under hold settings of one and two.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_unit_test;
    import i2cmb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM
    } sda_src_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                hold_we;
    logic [CFG_BITS-1:0] hold_wdata;
    logic [CFG_BITS-1:0] hold_now;
    logic                pauses_on;
    logic                last_busy;
    int                  ready_stall;
    int                  quiet_cycles;
    int                  fail_count;
    int                  pending;

    i2cmb_in_if  cmd_ch ();
    i2cmb_out_if res_ch ();

    always #10 clk = ~clk;

    i2c_master_bit_engine_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .hold_we    (hold_we),
        .hold_wdata (hold_wdata)
    );

    i2c_master_bit_engine_unit_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .hold_we    (hold_we),
        .hold_wdata (hold_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side back-pressure in short bursts
    always @(negedge clk)
    begin
        if (ready_stall > 0)
        begin
            res_ch.ready <= 1'b0;
            ready_stall--;
        end
        else if (pauses_on && $urandom_range(0, 7) == 0)
        begin
            res_ch.ready <= 1'b0;
            ready_stall = $urandom_range(1, 4) - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // Track engine activity and watch for a stalled run
    always @(posedge clk)
    begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            last_busy <= res_ch.busy_res;
        if (!rst_n || (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One tick transfer, with an optional gap ahead of it
    task automatic send_tick(logic cv, logic [2:0] m, logic [7:0] txb, logic ack,
                             sda_src_t src);
        int gap;
        @(negedge clk);
        if (pauses_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 4);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd_valid <= cv;
        cmd_ch.mode      <= m;
        cmd_ch.tx_byte   <= txb;
        cmd_ch.ack_out   <= ack;
        case (src)
            SDA_LOW:  cmd_ch.sda_in <= 1'b0;
            SDA_HIGH: cmd_ch.sda_in <= 1'b1;
            default:  cmd_ch.sda_in <= 1'($urandom_range(0, 1));
        endcase
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    endtask

    // Ticks without a command; the other fields carry noise
    task automatic idle_ticks(int n, sda_src_t src);
        repeat (n)
            send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                      src);
    endtask

    // Command tick, then idle ticks to cover its sequence; a negative slack
    // makes the next command land inside the sequence or on its done tick
    task automatic issue(logic [2:0] m, logic [7:0] txb, logic ack, sda_src_t src,
                         int slack);
        int span;
        span = int'(seq_len(mode_t'(m))) * int'(hold_load(hold_now));
        send_tick(1'b1, m, txb, ack, src);
        idle_ticks(span + slack, src);
    endtask

    // Let the sequencer finish and every result drain
    task automatic quiesce();
        idle_ticks(4, SDA_RANDOM);
        while (last_busy)
            idle_ticks(1, SDA_RANDOM);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_hold(logic [CFG_BITS-1:0] v);
        quiesce();
        @(negedge clk);
        hold_we    <= 1'b1;
        hold_wdata <= v;
        hold_now   = v;
        @(negedge clk);
        hold_we    <= 1'b0;
    endtask

    task automatic random_cmds(int n);
        logic [2:0] m;
        int         slack;
        int         pick;
        sda_src_t   src;
        repeat (n)
        begin
            if ($urandom_range(0, 19) == 0)
                m = 3'($urandom_range(6, 7));
            else
                m = 3'($urandom_range(MODE_START, MODE_RECV_ACK));
            pick = $urandom_range(0, 9);
            if (pick < 6)
                slack = $urandom_range(0, 3);
            else if (pick < 8)
                slack = -1;
            else
                slack = -int'($urandom_range(2, 6));
            case ($urandom_range(0, 7))
                0:       src = SDA_LOW;
                1:       src = SDA_HIGH;
                default: src = SDA_RANDOM;
            endcase
            issue(m, 8'($urandom), 1'($urandom_range(0, 1)), src, slack);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        hold_we          = 1'b0;
        hold_wdata       = '0;
        hold_now         = HOLD_RESET;
        pauses_on        = 1'b0;
        last_busy        = 1'b0;
        ready_stall      = 0;
        quiet_cycles     = 0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.cmd_valid = 1'b0;
        cmd_ch.mode      = '0;
        cmd_ch.tx_byte   = '0;
        cmd_ch.ack_out   = 1'b0;
        cmd_ch.sda_in    = 1'b1;
        res_ch.ready     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n     <= 1'b1;
        pauses_on = 1'b1;

        // One command at the reset hold
        issue(MODE_START,     8'h00, 1'b0, SDA_RANDOM, 0);

        // Zero hold behaves as one; directed pass
        set_hold('0);
        issue(MODE_START,     8'h00, 1'b0, SDA_RANDOM, 0);
        issue(MODE_SEND_BYTE, 8'hFF, 1'b0, SDA_RANDOM, 0);
        issue(MODE_SEND_BYTE, 8'h00, 1'b1, SDA_RANDOM, 0);
        issue(MODE_SEND_BYTE, 8'hA5, 1'b0, SDA_RANDOM, 0);
        issue(MODE_RECV_ACK,  8'h00, 1'b0, SDA_LOW,    0);
        issue(MODE_RECV_ACK,  8'h00, 1'b0, SDA_HIGH,   0);
        issue(MODE_RECV_BYTE, 8'h00, 1'b0, SDA_HIGH,   0);
        issue(MODE_RECV_BYTE, 8'h00, 1'b0, SDA_LOW,    0);
        issue(MODE_RECV_BYTE, 8'h00, 1'b0, SDA_RANDOM, 0);
        issue(MODE_SEND_ACK,  8'h00, 1'b0, SDA_RANDOM, 0);
        issue(MODE_SEND_ACK,  8'h00, 1'b1, SDA_RANDOM, 0);
        // codes six and seven leave the engine idle
        issue(3'd6,           8'h81, 1'b1, SDA_RANDOM, 3);
        issue(3'd7,           8'h7E, 1'b0, SDA_RANDOM, 3);
        // next command on the done tick, then one while busy
        issue(MODE_SEND_ACK,  8'h00, 1'b1, SDA_RANDOM, -1);
        issue(MODE_STOP,      8'h00, 1'b0, SDA_RANDOM, -3);
        issue(MODE_SEND_BYTE, 8'h5A, 1'b0, SDA_RANDOM, -20);
        issue(MODE_STOP,      8'h00, 1'b0, SDA_RANDOM, 20);
        issue(MODE_STOP,      8'h00, 1'b0, SDA_RANDOM, 0);

        set_hold(CFG_BITS'(1));
        random_cmds(15);

        set_hold(CFG_BITS'(2));
        random_cmds(7);

        // Closing stretch with no gaps on either side
        set_hold(CFG_BITS'(1));
        pauses_on = 1'b0;
        random_cmds(8);

        quiesce();
        repeat (5) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
